FILE: design/plrws_pkg.sv
// Shared definitions for the per-link round-trip-time window statistics block.
// Holds the sequencer state type, default sizes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package plrws_pkg;

	// Default number of links and samples held per link.
	localparam int LINKS_DEFAULT  = 8;
	localparam int WINDOW_DEFAULT = 8;

	// Value reported when no link has a usable minimum, and read for a link never written.
	localparam logic [15:0] NO_LINK_MIN = 16'd100;

	// Reset value of the active link count register.
	localparam logic [3:0] ACTIVE_RESET = 4'd8;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LUPD,
		S_RSCAN,
		S_RLAST,
		S_DIV,
		S_LWR,
		S_BSCAN,
		S_BLAST,
		S_DONE
	} state_t;

endpackage

FILE: design/per_link_rtt_window_stats.sv
// Top level of the per-link round-trip-time window statistics block.
// Depends on plrws_pkg and instantiates plrws_ram twice.
`timescale 1ns / 1ps

// Each input transaction carries a round-trip-time sample and a link index.
// When the link index is below the active link count (capped at LINKS), the
// sample goes into that link's ring of the last WINDOW samples, and the link's
// minimum and floored mean over the held samples are recomputed and reported
// together with the held count. Every transaction also reports the smallest
// nonzero minimum over the active links, a link never written counting as
// 100, or 100 when there is none. A link index at or above the active
// count changes nothing and reports zeros with accepted low. Exactly one
// output transaction follows every input transaction. The block works on
// one transaction at a time: in_ready is high only while the sequencer is
// idle, and an accepted sample passes through the link record update, the
// ring scan, the divider, the record write and the best scan before its
// result is offered; a rejected sample passes only through the best scan,
// or straight to the result when no link is active. The ring scan goes
// through the single read port of the sample memory, the mean comes from a
// one-bit-per-cycle restoring divider, and the best minimum comes from a
// scan over the per-link records. A finished result sits in an output
// register, so the next input transaction is taken while that result still
// waits for out_ready. The active link count is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, as the
// block itself does not enforce this. It resets to 8. The sample memory has
// no reset and needs no clearing pass, since only slots below a link's fill
// count are read. The per-link records use one valid flip-flop per link,
// cleared by reset.

module per_link_rtt_window_stats import plrws_pkg::*; #(
	parameter int LINKS  = LINKS_DEFAULT,
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  link_index,
	input  logic [15:0] rtt_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [15:0] window_min,
	output logic [15:0] window_mean,
	output logic [3:0]  held_count,
	output logic [15:0] best_link_min
);

	// Address and field widths derived from the sizes.
	localparam int LA    = (LINKS > 1) ? $clog2(LINKS) : 1;
	localparam int RD    = LINKS * WINDOW;
	localparam int RA    = (RD > 1) ? $clog2(RD) : 1;
	localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNW   = $clog2(WINDOW + 1);
	localparam int SUMW  = 16 + CNW;
	localparam int DSW   = $clog2(SUMW);

	// One record per link: stored minimum, fill count and next write slot.
	typedef struct packed {
		logic [15:0]     min;
		logic [CNW-1:0]  cnt;
		logic [SW-1:0]   slot;
	} lrec_t;

	localparam int LRW = $bits(lrec_t);

	state_t state_q, state_nxt;

	logic [3:0]      active_q;
	logic [3:0]      used;
	logic            link_ok;

	logic [LA-1:0]   link_q;
	logic [15:0]     rtt_q;
	logic [RA-1:0]   base_q;
	logic [LINKS-1:0] lvld_q;

	logic [CNW-1:0]  new_cnt_q;
	logic [SW-1:0]   new_slot_q;
	logic [CNW-1:0]  ridx_q;
	logic [3:0]      bidx_q;
	logic            pend_q;
	logic            bvld_q;
	logic [SUMW-1:0] sum_q;
	logic [15:0]     min_q;
	logic [SUMW-1:0] quo_q;
	logic [CNW-1:0]  rem_q;
	logic [DSW-1:0]  dstep_q;
	logic [15:0]     mean_q;
	logic [15:0]     best_q;
	logic            found_q;
	logic            ok_q;

	logic            out_valid_q;
	logic            accepted_q;
	logic [15:0]     window_min_q;
	logic [15:0]     window_mean_q;
	logic [3:0]      held_count_q;
	logic [15:0]     best_link_min_q;

	// Memory ports.
	logic            ring_we;
	logic [RA-1:0]   ring_waddr;
	logic [RA-1:0]   ring_raddr;
	logic [15:0]     ring_rdata;
	logic            lrec_we;
	logic [LA-1:0]   lrec_raddr;
	lrec_t           lrec_wdata;
	logic [LRW-1:0]  lrec_rbits;
	lrec_t           lrec_rdata;

	// Current link record, with reset values for a link never written.
	logic            cur_vld;
	logic [SW-1:0]   cur_slot;
	logic [CNW-1:0]  cur_cnt;
	logic [CNW-1:0]  next_cnt;
	logic [SW-1:0]   next_slot;

	// Shared compare unit, used by both the ring scan and the best scan.
	logic [15:0]     cmp_a;
	logic [15:0]     cmp_b;
	logic            cmp_lt;

	logic [15:0]     cand;
	logic [CNW:0]    trial;
	logic [CNW:0]    cnt_ext;
	logic            trial_ge;
	logic [CNW-1:0]  rem_nxt;
	logic [SUMW-1:0] sum_nxt;
	logic            in_fire;
	logic            out_free;

	assign lrec_rdata = lrec_t'(lrec_rbits);

	// Active count above LINKS behaves as LINKS.
	assign used    = (active_q > LINKS) ? 4'(LINKS) : active_q;
	assign link_ok = ({1'b0, link_index} < used);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign cur_vld   = lvld_q[link_q];
	assign cur_slot  = cur_vld ? lrec_rdata.slot : '0;
	assign cur_cnt   = cur_vld ? lrec_rdata.cnt : '0;
	assign next_slot = (cur_slot == SW'(WINDOW - 1)) ? '0 : cur_slot + SW'(1);
	assign next_cnt  = (cur_cnt < CNW'(WINDOW)) ? cur_cnt + CNW'(1) : cur_cnt;

	// An unwritten link reads as the reset minimum.
	assign cand = bvld_q ? lrec_rdata.min : NO_LINK_MIN;

	always_comb begin
		if (state_q == S_BSCAN || state_q == S_BLAST) begin
			cmp_a = cand;
			cmp_b = best_q;
		end else begin
			cmp_a = ring_rdata;
			cmp_b = min_q;
		end
	end

	assign cmp_lt  = (cmp_a < cmp_b);
	assign sum_nxt = sum_q + SUMW'(ring_rdata);

	// One restoring division step per cycle.
	assign trial    = {rem_q, quo_q[SUMW-1]};
	assign cnt_ext  = {1'b0, new_cnt_q};
	assign trial_ge = (trial >= cnt_ext);
	assign rem_nxt  = trial_ge ? CNW'(trial - cnt_ext) : CNW'(trial);

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (link_ok) begin
						state_nxt = S_LUPD;
					end else if (used == 4'd0) begin
						state_nxt = S_DONE;
					end else begin
						state_nxt = S_BSCAN;
					end
				end
			end
			S_LUPD: begin
				state_nxt = S_RSCAN;
			end
			S_RSCAN: begin
				if (ridx_q == new_cnt_q - CNW'(1)) begin
					state_nxt = S_RLAST;
				end
			end
			S_RLAST: begin
				state_nxt = S_DIV;
			end
			S_DIV: begin
				if (dstep_q == DSW'(SUMW - 1)) begin
					state_nxt = S_LWR;
				end
			end
			S_LWR: begin
				state_nxt = S_BSCAN;
			end
			S_BSCAN: begin
				if (bidx_q == used - 4'd1) begin
					state_nxt = S_BLAST;
				end
			end
			S_BLAST: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Memory controls and handshake outputs.
	always_comb begin
		in_ready   = 1'b0;
		ring_we    = 1'b0;
		lrec_we    = 1'b0;
		lrec_raddr = LA'(bidx_q);
		ring_waddr = base_q + RA'(cur_slot);
		ring_raddr = base_q + RA'(ridx_q);
		lrec_wdata = '{min: min_q, cnt: new_cnt_q, slot: new_slot_q};
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				lrec_raddr = LA'(link_index);
			end
			S_LUPD: begin
				ring_we = 1'b1;
			end
			S_LWR: begin
				lrec_we = 1'b1;
			end
			S_RSCAN, S_RLAST, S_DIV, S_BSCAN, S_BLAST, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign window_min    = window_min_q;
	assign window_mean   = window_mean_q;
	assign held_count    = held_count_q;
	assign best_link_min = best_link_min_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= ACTIVE_RESET;
			lvld_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (state_q == S_LWR) begin
				lvld_q[link_q] <= 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					link_q  <= LA'(link_index);
					rtt_q   <= rtt_sample;
					base_q  <= RA'(int'(link_index) * WINDOW);
					ok_q    <= link_ok;
					bidx_q  <= '0;
					pend_q  <= 1'b0;
					found_q <= 1'b0;
					best_q  <= '0;
				end
			end
			S_LUPD: begin
				new_cnt_q  <= next_cnt;
				new_slot_q <= next_slot;
				ridx_q     <= '0;
				pend_q     <= 1'b0;
				sum_q      <= '0;
				min_q      <= 16'hFFFF;
			end
			S_RSCAN: begin
				ridx_q <= ridx_q + CNW'(1);
				pend_q <= 1'b1;
				if (pend_q) begin
					sum_q <= sum_nxt;
					if (cmp_lt) begin
						min_q <= ring_rdata;
					end
				end
			end
			S_RLAST: begin
				if (cmp_lt) begin
					min_q <= ring_rdata;
				end
				quo_q   <= sum_nxt;
				rem_q   <= '0;
				dstep_q <= '0;
			end
			S_DIV: begin
				rem_q   <= rem_nxt;
				quo_q   <= {quo_q[SUMW-2:0], trial_ge};
				dstep_q <= dstep_q + DSW'(1);
			end
			S_LWR: begin
				mean_q <= quo_q[15:0];
				bidx_q <= '0;
				pend_q <= 1'b0;
			end
			S_BSCAN: begin
				bidx_q <= bidx_q + 4'd1;
				bvld_q <= lvld_q[LA'(bidx_q)];
				pend_q <= 1'b1;
				if (pend_q && cand != 16'd0 && (!found_q || cmp_lt)) begin
					best_q  <= cand;
					found_q <= 1'b1;
				end
			end
			S_BLAST: begin
				if (cand != 16'd0 && (!found_q || cmp_lt)) begin
					best_q  <= cand;
					found_q <= 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					accepted_q      <= ok_q;
					window_min_q    <= ok_q ? min_q : 16'd0;
					window_mean_q   <= ok_q ? mean_q : 16'd0;
					held_count_q    <= ok_q ? 4'(new_cnt_q) : 4'd0;
					best_link_min_q <= found_q ? best_q : NO_LINK_MIN;
				end
			end
			default: begin
			end
		endcase
	end

	plrws_ram #(
		.WIDTH (16),
		.DEPTH (RD),
		.AW    (RA)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (rtt_q),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	plrws_ram #(
		.WIDTH (LRW),
		.DEPTH (LINKS),
		.AW    (LA)
	) u_lrec (
		.clk   (clk),
		.we    (lrec_we),
		.waddr (link_q),
		.wdata (LRW'(lrec_wdata)),
		.raddr (lrec_raddr),
		.rdata (lrec_rbits)
	);

endmodule

FILE: design/plrws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the sample rings and the per-link records. No dependencies.
`timescale 1ns / 1ps

module plrws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
